// ===== rtl/fifo_with_service_time_lookup_assert.svh =====
// Assertion macros shared by the checker of the service time FIFO.
`ifndef FIFO_WITH_SERVICE_TIME_LOOKUP_ASSERT_SVH
`define FIFO_WITH_SERVICE_TIME_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FWST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FWST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fwst_pkg.sv =====
// Package: types, constants and helpers of the service time FIFO.
package fwst_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = 16 + CNT_W;
  localparam int CMP_W = (SUM_W > 24) ? SUM_W : 24;

  // Command codes
  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_FIND = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] entry_id;
    logic [15:0] service_time;
    logic [23:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] head_id;
    logic [15:0] head_time;
    logic        is_empty;
    logic [4:0]  occupancy;
    logic        found;
    logic [15:0] found_id;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_HEAD_RD,
    S_HEAD_LD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic ld_in;
    logic do_exec;
    logic walk_take;
    logic walk_done;
    logic ld_out;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       walk_more;
    logic       out_free;
  } stat_t;

  // Advance a ring index, wrapping at DEPTH
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/fwst_ctrl.sv =====
// Controller: sequences command execution, the find walk and result load.
module fwst_ctrl
  import fwst_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  output logic  cmd_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (cmd_valid) state_next = S_EXEC;
      S_EXEC:    state_next = (stat.cmd == CMD_FIND) ? S_WALK : S_HEAD_RD;
      S_WALK:    if (!stat.walk_more) state_next = S_HEAD_RD;
      S_HEAD_RD: state_next = S_HEAD_LD;
      S_HEAD_LD: if (stat.out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl      = '0;
    cmd_ready = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_ready  = 1'b1;
        ctrl.ld_in = cmd_valid;
      end
      S_EXEC:    ctrl.do_exec = 1'b1;
      S_WALK: begin
        ctrl.walk_take = stat.walk_more;
        ctrl.walk_done = !stat.walk_more;
      end
      S_HEAD_RD: ;
      S_HEAD_LD: ctrl.ld_out = stat.out_free;
      default:   ;
    endcase
  end

endmodule

// ===== rtl/fwst_datapath.sv =====
// Datapath: ring storage, pointers, prefix-sum walk and result register.
module fwst_datapath
  import fwst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  cmd_data,
  input  ctrl_t     ctrl,
  output stat_t     stat,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_item_t rsp_data
);

  logic [15:0] id_mem   [DEPTH];
  logic [15:0] time_mem [DEPTH];

  in_item_t         item;
  logic [PTR_W-1:0] front_ptr, rear_ptr, pos, rd_addr, pos_inc;
  logic [CNT_W-1:0] entry_count, walked;
  logic [SUM_W-1:0] sum;
  logic [15:0]      last_id, rd_id, rd_time, found_id;
  logic             found;
  logic [1:0]       status;
  logic             is_full, is_empty, walk_more;
  logic [CMP_W-1:0] sum_ext, q_ext;

  assign is_full  = (entry_count == CNT_W'(DEPTH));
  assign is_empty = (entry_count == '0);
  assign pos_inc  = ring_next(pos);
  assign sum_ext  = CMP_W'(sum);
  assign q_ext    = CMP_W'(item.query_time);
  assign walk_more = (sum_ext < q_ext) && (walked < entry_count);

  assign stat.cmd       = item.cmd;
  assign stat.walk_more = walk_more;
  assign stat.out_free  = !rsp_valid || rsp_ready;

  // Single read port: walk follows pos, otherwise the front entry
  assign rd_addr = ctrl.walk_take ? pos_inc : front_ptr;

  // Storage: write at rear on enqueue, registered read
  always_ff @(posedge clk) begin
    if (ctrl.do_exec && item.cmd == CMD_ENQ && !is_full) begin
      id_mem[rear_ptr]   <= item.entry_id;
      time_mem[rear_ptr] <= item.service_time;
    end
    rd_id   <= id_mem[rd_addr];
    rd_time <= time_mem[rd_addr];
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (ctrl.ld_in) item <= cmd_data;
  end

  // Ring pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      front_ptr   <= '0;
      rear_ptr    <= '0;
      entry_count <= '0;
    end else if (ctrl.do_exec) begin
      if (item.cmd == CMD_ENQ && !is_full) begin
        rear_ptr    <= ring_next(rear_ptr);
        entry_count <= entry_count + 1'b1;
      end else if (item.cmd == CMD_DEQ && !is_empty) begin
        front_ptr   <= ring_next(front_ptr);
        entry_count <= entry_count - 1'b1;
      end
    end
  end

  // Status of the command
  always_ff @(posedge clk) begin
    if (ctrl.do_exec) begin
      if (item.cmd == CMD_ENQ && is_full) begin
        status <= ST_FULL;
      end else if (item.cmd == CMD_DEQ && is_empty) begin
        status <= ST_EMPTY;
      end else begin
        status <= ST_OK;
      end
    end
  end

  // Prefix-sum walk, one entry per cycle
  always_ff @(posedge clk) begin
    if (ctrl.do_exec) begin
      pos     <= front_ptr;
      sum     <= '0;
      walked  <= '0;
      last_id <= '0;
    end else if (ctrl.walk_take) begin
      pos     <= pos_inc;
      sum     <= sum + SUM_W'(rd_time);
      walked  <= walked + 1'b1;
      last_id <= rd_id;
    end
  end

  // Find outcome: exact hit takes the following entry, overshoot the last one
  always_ff @(posedge clk) begin
    if (ctrl.ld_in) begin
      found    <= 1'b0;
      found_id <= '0;
    end else if (ctrl.walk_done) begin
      if (sum_ext == q_ext && walked < entry_count) begin
        found    <= 1'b1;
        found_id <= rd_id;
      end else if (sum_ext > q_ext) begin
        found    <= 1'b1;
        found_id <= last_id;
      end else begin
        found    <= 1'b0;
        found_id <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.ld_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      rsp_data.status    <= status;
      rsp_data.head_id   <= is_empty ? 16'd0 : rd_id;
      rsp_data.head_time <= is_empty ? 16'd0 : rd_time;
      rsp_data.is_empty  <= is_empty;
      rsp_data.occupancy <= 5'(entry_count);
      rsp_data.found     <= found;
      rsp_data.found_id  <= found_id;
    end
  end

endmodule

// ===== rtl/fifo_with_service_time_lookup.sv =====
// Top level of the FIFO with service time lookup.
//
// A FIFO of (id, service time) entries with a prefix-sum search.
// Command channel (cmd_valid/cmd_ready/cmd_data): one beat carries
// enqueue, dequeue or find. Response channel (rsp_valid/rsp_ready/
// rsp_data): exactly one beat per command, in order, with status, head
// entry, empty flag, occupancy and the find outcome.
// After accept, a command steps through the execute, head read and
// head load states before the response is valid; only a find walks
// n entries between execute and head read, n being the entries summed
// (at most DEPTH), reading one entry per cycle through the single
// read port of the storage. One command is in progress at a time;
// cmd_ready is high only when the previous command has been loaded
// into the response register.
// The next command is accepted while a response waits to be taken.
// If the receiver stalls, the response holds and a following command
// waits at its final load step until the response register frees.
// Reset clears pointers, count and the response valid; entry storage
// is not cleared and its contents are used only where written.
module fifo_with_service_time_lookup
  import fwst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  in_item_t  cmd_data,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_item_t rsp_data
);

  ctrl_t ctrl;
  stat_t stat;

  fwst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  fwst_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd_data  (cmd_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

// ===== rtl/fwst_checker.sv =====
// Port-level checker for the service time FIFO, with its bind.
`include "fifo_with_service_time_lookup_assert.svh"

module fwst_checker
  import fwst_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_ready,
  input in_item_t  cmd_data,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input out_item_t rsp_data
);

  // A stalled response beat holds
  `FWST_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")

  // An empty queue reports no occupancy and a zero head
  `FWST_ASSERT_NOW(a_empty_occ, rsp_valid && rsp_data.is_empty, rsp_data.occupancy == 5'd0, "empty with nonzero occupancy")
  `FWST_ASSERT_NOW(a_empty_head, rsp_valid && rsp_data.is_empty, rsp_data.head_id == 16'd0 && rsp_data.head_time == 16'd0, "empty with nonzero head")

  // No found id without a hit
  `FWST_ASSERT_NOW(a_found_id, rsp_valid && !rsp_data.found, rsp_data.found_id == 16'd0, "found id without a hit")

endmodule

bind fifo_with_service_time_lookup fwst_checker u_fwst_checker (.*);

// ===== tb/sv/testbench.sv =====
// Service time FIFO testbench: directed and random commands checked against a predictor.
`timescale 1ns / 100ps

module testbench;
  import fwst_pkg::*;

  // Unused command code: queue unchanged, head fields reported
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int MAX_PRINTED = 100;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_ready;
  in_item_t  cmd_data = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  out_item_t rsp_data;

  // Stimulus and scoreboard bookkeeping
  in_item_t  pending_cmds[$];
  out_item_t expected_rsps[$];
  int        plan_times[$];
  int        items_queued = 0;
  int        rsps_taken = 0;
  int        error_count = 0;
  int        cycle_count = 0;
  int        sender_idle_pct = 0;
  int        rcv_idle_pct = 0;
  bit        cmd_beat_taken = 1'b0;

  // Predictor copy of the ring
  logic [15:0] ring_ids[DEPTH];
  logic [15:0] ring_times[DEPTH];
  int          ring_front = 0;
  int          ring_rear = 0;
  int          ring_fill = 0;

  fifo_with_service_time_lookup dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("ERROR cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // Apply one command to the predictor ring and build the expected response
  task automatic predict_fifo_response(input in_item_t beat, output out_item_t rsp);
    logic [31:0] run_sum;
    int          walked;
    int          pos;
    int          last_pos;
    rsp = '0;
    rsp.status = ST_OK;
    case (beat.cmd)
      CMD_ENQ: begin
        if (ring_fill >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          ring_ids[ring_rear] = beat.entry_id;
          ring_times[ring_rear] = beat.service_time;
          ring_rear = (ring_rear + 1) % DEPTH;
          ring_fill++;
        end
      end
      CMD_DEQ: begin
        if (ring_fill == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          ring_front = (ring_front + 1) % DEPTH;
          ring_fill--;
        end
      end
      CMD_FIND: begin
        run_sum = '0;
        walked = 0;
        pos = ring_front;
        last_pos = pos;
        // accumulate service times until the query time is reached
        while (run_sum < {8'd0, beat.query_time} && walked < ring_fill) begin
          run_sum += {16'd0, ring_times[pos]};
          last_pos = pos;
          pos = (pos + 1) % DEPTH;
          walked++;
        end
        if (run_sum == {8'd0, beat.query_time} && walked < ring_fill) begin
          rsp.found = 1'b1;
          rsp.found_id = ring_ids[pos];
        end else if (run_sum > {8'd0, beat.query_time}) begin
          rsp.found = 1'b1;
          rsp.found_id = ring_ids[last_pos];
        end
      end
      default: begin
      end
    endcase
    if (ring_fill != 0) begin
      rsp.head_id = ring_ids[ring_front];
      rsp.head_time = ring_times[ring_front];
    end else begin
      rsp.is_empty = 1'b1;
    end
    rsp.occupancy = 5'(ring_fill);
  endtask

  task automatic compare_response(input out_item_t got, input out_item_t want);
    if (got.status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.head_id !== want.head_id)
      report_mismatch($sformatf("head_id got %h want %h", got.head_id, want.head_id));
    if (got.head_time !== want.head_time)
      report_mismatch($sformatf("head_time got %h want %h", got.head_time, want.head_time));
    if (got.is_empty !== want.is_empty)
      report_mismatch($sformatf("is_empty got %b want %b", got.is_empty, want.is_empty));
    if (got.occupancy !== want.occupancy)
      report_mismatch($sformatf("occupancy got %0d want %0d", got.occupancy, want.occupancy));
    if (got.found !== want.found)
      report_mismatch($sformatf("found got %b want %b", got.found, want.found));
    if (got.found_id !== want.found_id)
      report_mismatch($sformatf("found_id got %h want %h", got.found_id, want.found_id));
  endtask

  // Queue one command; plan_times tracks service times as they will stand
  task automatic queue_cmd(input logic [1:0] op, input logic [15:0] id,
                           input logic [15:0] svc, input logic [23:0] qry);
    in_item_t beat;
    beat.cmd = op;
    beat.entry_id = id;
    beat.service_time = svc;
    beat.query_time = qry;
    pending_cmds.push_back(beat);
    items_queued++;
    if (op == CMD_ENQ && plan_times.size() < DEPTH) begin
      plan_times.push_back(int'(svc));
    end else if (op == CMD_DEQ && plan_times.size() != 0) begin
      void'(plan_times.pop_front());
    end
  endtask

  // Bursts that fill, drain, mix or search; queries mostly lie on or next to prefix sums
  task automatic queue_random_cmds(input int count);
    int          mode;
    int          burst_left;
    int          pick;
    int          enq_cut;
    int          deq_cut;
    int          k;
    logic [1:0]  op;
    logic [15:0] svc;
    logic [23:0] qry;
    logic [31:0] prefix;
    burst_left = 0;
    mode = 0;
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        mode = $urandom_range(3);
        burst_left = $urandom_range(24, 4);
      end
      burst_left--;
      case (mode)
        0: begin enq_cut = 65; deq_cut = 75; end
        1: begin enq_cut = 10; deq_cut = 75; end
        2: begin enq_cut = 35; deq_cut = 65; end
        default: begin enq_cut = 15; deq_cut = 25; end
      endcase
      pick = $urandom_range(99);
      if (pick < enq_cut) op = CMD_ENQ;
      else if (pick < deq_cut) op = CMD_DEQ;
      else if (pick < 97) op = CMD_FIND;
      else op = CMD_SPARE;

      pick = $urandom_range(99);
      if (pick < 30) svc = 16'($urandom_range(3));
      else if (pick < 40) svc = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      else svc = 16'($urandom);

      pick = $urandom_range(99);
      if (pick < 8) begin
        qry = '0;
      end else if (pick < 14) begin
        qry = 24'($urandom);
      end else if (pick < 18) begin
        qry = 24'hFF_FFFF;
      end else begin
        k = $urandom_range(plan_times.size());
        prefix = '0;
        for (int i = 0; i < k; i++) prefix += 32'(plan_times[i]);
        // just below, on, or just past the boundary
        case ($urandom_range(2))
          0: if (prefix != 0) prefix = prefix - 1;
          2: prefix = prefix + 1;
          default: begin
          end
        endcase
        qry = prefix[23:0];
      end
      queue_cmd(op, 16'($urandom), svc, qry);
    end
  endtask

  task automatic wait_for_drain();
    while (rsps_taken != items_queued) @(negedge clk);
  endtask

  // Driver: command beats and response back-pressure, changed at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_beat_taken) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        cmd_valid <= 1'b1;
        cmd_data <= pending_cmds.pop_front();
      end else begin
        cmd_valid <= 1'b0;
      end
    end
    rsp_ready <= !rst && ($urandom_range(99) >= rcv_idle_pct);
  end

  // Monitor: predict on each accepted command, check each accepted response
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAIL fifo_with_service_time_lookup");
        $finish;
      end else begin
        // flag for the driver: a command beat went through at this edge
        cmd_beat_taken = cmd_valid && cmd_ready;
        if (cmd_valid && cmd_ready) begin
          predict_fifo_response(cmd_data, want);
          expected_rsps.push_back(want);
        end
        if (rsp_valid && rsp_ready) begin
          rsps_taken++;
          if (expected_rsps.size() == 0) begin
            report_mismatch("response beat with no command outstanding");
          end else begin
            want = expected_rsps.pop_front();
            compare_response(rsp_data, want);
          end
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    sender_idle_pct = 35;
    rcv_idle_pct = 51;
    // empty queue corners
    queue_cmd(CMD_DEQ, 16'h0000, 16'h0000, 24'h00_0000);
    queue_cmd(CMD_FIND, 16'h0000, 16'h0000, 24'h00_0000);
    queue_cmd(CMD_FIND, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF);
    queue_cmd(CMD_SPARE, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF);
    // field extremes, then searches around the prefix sums FFFF, FFFF, 10002
    queue_cmd(CMD_ENQ, 16'hFFFF, 16'hFFFF, 24'h00_0000);
    queue_cmd(CMD_ENQ, 16'h0000, 16'h0000, 24'hFF_FFFF);
    queue_cmd(CMD_ENQ, 16'h1234, 16'h0003, 24'h00_0000);
    queue_cmd(CMD_FIND, 16'h0000, 16'h0000, 24'h00_0000);
    queue_cmd(CMD_FIND, 16'h0000, 16'h0000, 24'h00_FFFF);
    queue_cmd(CMD_FIND, 16'h0000, 16'h0000, 24'h01_0002);
    queue_cmd(CMD_FIND, 16'h0000, 16'h0000, 24'h01_0001);
    queue_cmd(CMD_FIND, 16'h0000, 16'h0000, 24'hFF_FFFF);
    queue_cmd(CMD_FIND, 16'h0000, 16'h0000, 24'h00_0005);
    queue_cmd(CMD_SPARE, 16'h0000, 16'h0000, 24'h00_0000);
    // fill to capacity, then enqueue on a full queue
    for (int i = 0; i < DEPTH - 3; i++) begin
      queue_cmd(CMD_ENQ, 16'($urandom), 16'(i), 24'h00_0000);
    end
    queue_cmd(CMD_ENQ, 16'hABCD, 16'h5555, 24'h00_0000);
    queue_cmd(CMD_FIND, 16'h0000, 16'h0000, 24'hFF_FFFF);
    wait_for_drain();

    queue_random_cmds(433);
    wait_for_drain();

    sender_idle_pct = 51;
    rcv_idle_pct = 35;
    queue_random_cmds(433);
    wait_for_drain();

    sender_idle_pct = 0;
    rcv_idle_pct = 0;
    queue_random_cmds(433);
    wait_for_drain();

    // let any stray response show up
    repeat (30) @(negedge clk);
    if (error_count == 0) begin
      $display("PASS fifo_with_service_time_lookup");
    end else begin
      $display("FAIL fifo_with_service_time_lookup");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fwst_pkg.sv
rtl/fwst_ctrl.sv
rtl/fwst_datapath.sv
rtl/fifo_with_service_time_lookup.sv
rtl/fwst_checker.sv
tb/sv/testbench.sv
